// ===== src/dda_line_rasterizer_unit_defines.svh =====
// Assertion macros used by the line rasteriser RTL.
// Depends on nothing; included by dlr_ctrl, which carries the concurrent checks.
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dlr_pkg.sv =====
// Shared widths, defaults and controller/datapath command types.
// No dependencies; imported by every module of the line rasteriser.
package dlr_pkg;

  localparam int CoordW      = 6;   // endpoint and cell width
  localparam int DeltaW      = 7;   // signed endpoint difference
  localparam int StepW       = 7;   // step count and step index
  localparam int GridSizeDef = 64;  // default grid edge length

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seg;    // capture a new segment
    logic emit_point;  // load the output register and advance one step
  } dlr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_last;     // current point is the final one of the segment
  } dlr_sts_t;

endpackage

// ===== src/dlr_axis.sv =====
// One coordinate axis: exact quotient/remainder stepping with half-away rounding.
// Depends on dlr_pkg.
module dlr_axis
  import dlr_pkg::*;
#(
  parameter int CentreOfs = GridSizeDef / 2
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     advance,
  input  logic signed [CoordW-1:0] start,
  input  logic signed [DeltaW-1:0] delta,
  input  logic        [StepW-1:0]  steps,
  output logic        [CoordW-1:0] grid_pos
);

  localparam logic [CoordW-1:0] OfsBits = CoordW'(CentreOfs);

  // Point value is q + r/steps, with 0 <= r < steps.
  logic signed [DeltaW-1:0]   q;
  logic        [CoordW-1:0]   r;
  logic signed [DeltaW-1:0]   q_next;
  logic        [CoordW-1:0]   r_next;
  logic        [StepW-1:0]    twice_r;
  logic                       round_up;
  logic signed [DeltaW-1:0]   rounded;
  logic signed [DeltaW:0]     r_sum;
  logic signed [DeltaW:0]     steps_s;

  // Round half away from zero: a tie rounds up only for non-negative values.
  assign twice_r  = {r, 1'b0};
  assign round_up = (twice_r > steps) || ((twice_r == steps) && (r != '0) && !q[DeltaW-1]);
  assign rounded  = q + DeltaW'(round_up);
  assign grid_pos = rounded[CoordW-1:0] + OfsBits;

  // |delta| <= steps, so one correction keeps r in range.
  assign r_sum   = $signed({2'b00, r}) + $signed({delta[DeltaW-1], delta});
  assign steps_s = $signed({1'b0, steps});

  always_comb begin
    q_next = q;
    r_next = r;
    if (load) begin
      q_next = DeltaW'(start);
      r_next = '0;
    end else if (advance) begin
      if (r_sum >= steps_s) begin
        q_next = q + DeltaW'(1);
        r_next = CoordW'(r_sum - steps_s);
      end else if (r_sum < 0) begin
        q_next = q - DeltaW'(1);
        r_next = CoordW'(r_sum + steps_s);
      end else begin
        r_next = CoordW'(r_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    r <= r_next;
  end

endmodule

// ===== src/dlr_datapath.sv =====
// Segment setup, step counter, two axis units and the output register.
// Depends on dlr_pkg and dlr_axis.
module dlr_datapath
  import dlr_pkg::*;
#(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dlr_cmd_t                 cmd,
  output dlr_sts_t                 sts,
  input  logic signed [CoordW-1:0] x_start,
  input  logic signed [CoordW-1:0] y_start,
  input  logic signed [CoordW-1:0] x_end,
  input  logic signed [CoordW-1:0] y_end,
  output logic        [CoordW-1:0] col,
  output logic        [CoordW-1:0] row,
  output logic                     last_point
);

  logic signed [DeltaW-1:0] dx;
  logic signed [DeltaW-1:0] dy;
  logic        [StepW-1:0]  adx;
  logic        [StepW-1:0]  ady;
  logic        [StepW-1:0]  steps_in;

  logic signed [DeltaW-1:0] seg_delta_x;
  logic signed [DeltaW-1:0] seg_delta_y;
  logic        [StepW-1:0]  step_total;
  logic        [StepW-1:0]  step_index;
  logic        [CoordW-1:0] cell_x;
  logic        [CoordW-1:0] cell_y;

  // Segment setup on the accepted request.
  assign dx       = DeltaW'(x_end) - DeltaW'(x_start);
  assign dy       = DeltaW'(y_end) - DeltaW'(y_start);
  assign adx      = dx[DeltaW-1] ? StepW'(-dx) : StepW'(dx);
  assign ady      = dy[DeltaW-1] ? StepW'(-dy) : StepW'(dy);
  assign steps_in = (adx > ady) ? adx : ady;

  assign sts.at_last = (step_index == step_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_delta_x <= '0;
      seg_delta_y <= '0;
      step_total  <= '0;
      step_index  <= '0;
    end else if (cmd.load_seg) begin
      seg_delta_x <= dx;
      seg_delta_y <= dy;
      step_total  <= steps_in;
      step_index  <= '0;
    end else if (cmd.emit_point) begin
      step_index  <= step_index + StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_point) begin
      col        <= cell_x;
      row        <= cell_y;
      last_point <= sts.at_last;
    end
  end

  dlr_axis #(.CentreOfs(GRID_SIZE / 2)) u_axis_x (
    .clk      (clk),
    .load     (cmd.load_seg),
    .advance  (cmd.emit_point),
    .start    (x_start),
    .delta    (seg_delta_x),
    .steps    (step_total),
    .grid_pos (cell_x)
  );

  dlr_axis #(.CentreOfs(GRID_SIZE / 2)) u_axis_y (
    .clk      (clk),
    .load     (cmd.load_seg),
    .advance  (cmd.emit_point),
    .start    (y_start),
    .delta    (seg_delta_y),
    .steps    (step_total),
    .grid_pos (cell_y)
  );

endmodule

// ===== src/dlr_ctrl.sv =====
// Controller: accepts a segment, then paces one point per free output slot.
// Depends on dlr_pkg and the assertion macro header.
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_ctrl
  import dlr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dlr_cmd_t cmd,
  input  dlr_sts_t sts
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready       = (state == ST_IDLE);
  assign cmd.load_seg   = in_ready && in_valid;
  assign cmd.emit_point = (state == ST_RUN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid)                      state_next = ST_RUN;
      ST_RUN:  if (cmd.emit_point && sts.at_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit_point)  out_valid_next = 1'b1;
    else if (out_ready)  out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `DLR_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.emit_point, !out_valid || out_ready, "point overwrites an untaken result")
  `DLR_ASSERT_NEXT(a_load_runs, clk, rst, cmd.load_seg, !in_ready && !cmd.load_seg, "segment load did not start a run")
  `DLR_ASSERT_NEXT(a_last_frees, clk, rst, cmd.emit_point && sts.at_last, in_ready && out_valid, "final point did not release the input")
  `DLR_ASSERT_NOW(a_idle_quiet, clk, rst, in_ready, !cmd.emit_point, "point emitted with no segment in flight")

endmodule

// ===== src/dda_line_rasterizer_unit.sv =====
// Top level of the DDA line rasteriser: controller plus datapath.
// Depends on dlr_pkg, dlr_ctrl and dlr_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request: a segment given by
//   two signed endpoints x_start, y_start, x_end, y_end relative to the grid
//   centre. Output channel (out_valid/out_ready) returns steps+1 points, where
//   steps is the larger absolute delta; each carries col, row (coordinate plus
//   GRID_SIZE/2, modulo 64) and last_point, set on the final point only.
//   The request is captured into the segment registers and axis units; the
//   first point then passes through the output register once it is free.
//   Points then follow at one point per cycle while the receiver is ready.
//   Each point is exact: a quotient and remainder per axis advance by the delta
//   each step and are rounded half away from zero, with no division.
//   in_ready rises as soon as the final point is loaded, so the next request
//   is taken while that point still waits in the output register.
//   Stall: with out_ready low the output register holds its point and the
//   stepping pauses; nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) returns to idle and drops any
//   request in flight and any result not yet taken.
module dda_line_rasterizer_unit
  import dlr_pkg::*;
#(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] x_start,
  input  logic signed [CoordW-1:0] y_start,
  input  logic signed [CoordW-1:0] x_end,
  input  logic signed [CoordW-1:0] y_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [CoordW-1:0] col,
  output logic        [CoordW-1:0] row,
  output logic                     last_point
);

  dlr_cmd_t cmd;
  dlr_sts_t sts;

  // Sequencing: idle until a request, then one point per free output slot.
  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic: segment setup, per-axis stepping and the output register.
  dlr_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .col        (col),
    .row        (row),
    .last_point (last_point)
  );

endmodule

// ===== tb/sv/dda_line_rasterizer_unit_tb.sv =====
// Self-checking testbench for dda_line_rasterizer_unit: drives segment requests, predicts
// every plotted point and checks col, row and last_point in order.
// Depends on dlr_pkg and the dda_line_rasterizer_unit RTL.
`timescale 1ns / 1ps

module dda_line_rasterizer_unit_tb;
  import dlr_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;

  // One plotted grid cell as the block should present it.
  typedef struct {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
  } grid_cell_t;

  // Predicts the points of each accepted segment and checks the block's points in order.
  class raster_point_scoreboard;
    grid_cell_t pending_points[$];
    int         mismatch_count;
    int         points_checked;
    int         segments_seen;
    int         longest_segment;

    function new();
      mismatch_count  = 0;
      points_checked  = 0;
      segments_seen   = 0;
      longest_segment = 0;
    endfunction

    // Exact rational rounded half away from zero; den is always positive.
    function int round_half_away(int num, int den);
      if (num >= 0) return (2 * num + den) / (2 * den);
      return -((-2 * num + den) / (2 * den));
    endfunction

    // Add the centre offset and keep the low bits of the sum.
    function logic [CoordW-1:0] to_cell(int v);
      int sum;
      sum = v + GridSizeDef / 2;
      return sum[CoordW-1:0];
    endfunction

    // Note an accepted segment request and queue every point it must produce.
    function void note_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
      int sx, sy, dx, dy, adx, ady, steps;
      grid_cell_t pt;
      sx    = xs;
      sy    = ys;
      dx    = int'(xe) - sx;
      dy    = int'(ye) - sy;
      adx   = (dx < 0) ? -dx : dx;
      ady   = (dy < 0) ? -dy : dy;
      steps = (adx > ady) ? adx : ady;
      segments_seen++;
      if (steps > longest_segment) longest_segment = steps;
      if (steps == 0) begin
        // Zero-length segment: a single point at the start, flagged as last.
        pt.col  = to_cell(sx);
        pt.row  = to_cell(sy);
        pt.last = 1'b1;
        pending_points.push_back(pt);
        return;
      end
      for (int i = 0; i <= steps; i++) begin
        pt.col  = to_cell(round_half_away(sx * steps + i * dx, steps));
        pt.row  = to_cell(round_half_away(sy * steps + i * dy, steps));
        pt.last = (i == steps);
        pending_points.push_back(pt);
      end
    endfunction

    // Compare one accepted point with the oldest prediction.
    function void check_point(logic [CoordW-1:0] col, logic [CoordW-1:0] row, logic last);
      grid_cell_t exp_pt;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected point col %0d row %0d last %0b", $time, col, row, last);
        return;
      end
      exp_pt = pending_points.pop_front();
      points_checked++;
      if (col !== exp_pt.col || row !== exp_pt.row || last !== exp_pt.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: point %0d mismatch: expected col %0d row %0d last %0b, got col %0d row %0d last %0b",
                   $time, points_checked, exp_pt.col, exp_pt.row, exp_pt.last, col, row, last);
      end
    endfunction

    function int pending_count();
      return pending_points.size();
    endfunction
  endclass

  // Generous bound: 420 full-length segments with the receiver stalling heavily fit well inside.
  localparam int CycleLimit   = 2_000_000;
  localparam int RandomItems  = 400;
  localparam int DrainCycles  = 20;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  logic   out_valid;
  logic   out_ready;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  logic   last_point;

  int send_idle_pct;  // chance in a hundred that the sender holds off a cycle
  int take_idle_pct;  // chance in a hundred that the receiver stalls a cycle
  int cycle_count;

  raster_point_scoreboard point_board;

  dda_line_rasterizer_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .col        (col),
    .row        (row),
    .last_point (last_point)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold every input at a known value from time zero.
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    x_start       = '0;
    y_start       = '0;
    x_end         = '0;
    y_end         = '0;
    out_ready     = 1'b0;
    send_idle_pct = 38;
    take_idle_pct = 88;
    point_board   = new();
  end

  // Bound the run; a hang in either channel ends here.
  always @(posedge clk) begin
    cycle_count <= (rst) ? 0 : cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d points outstanding", $time, point_board.pending_count());
      $display("dda_line_rasterizer_unit regression: fail");
      $finish;
    end
  end

  // Receiver: decide readiness at each falling edge, stalling at the current phase's rate.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Sample both channels at the rising edge: note taken requests, check taken points.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) point_board.note_segment(x_start, y_start, x_end, y_end);
      if (out_valid && out_ready) point_board.check_point(col, row, last_point);
    end
  end

  // Offer one segment request. Entered and left at a falling edge; valid stays up,
  // payload unchanged, until the request is taken.
  task automatic send_segment(int xs, int ys, int xe, int ye);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_start  <= coord_t'(xs);
    y_start  <= coord_t'(ys);
    x_end    <= coord_t'(xe);
    y_end    <= coord_t'(ye);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic int clamp_coord(int v);
    if (v < -32) return -32;
    if (v > 31)  return 31;
    return v;
  endfunction

  // Random segment: mostly anywhere on the grid, some short, some axis-aligned or diagonal.
  task automatic send_random_segment();
    int kind, xs, ys, xe, ye, d;
    kind = $urandom_range(9);
    xs   = int'($urandom_range(63)) - 32;
    ys   = int'($urandom_range(63)) - 32;
    if (kind <= 5) begin
      xe = int'($urandom_range(63)) - 32;
      ye = int'($urandom_range(63)) - 32;
    end else if (kind <= 8) begin
      // Short segments turn requests over quickly, stressing back-to-back acceptance.
      xe = clamp_coord(xs + int'($urandom_range(8)) - 4);
      ye = clamp_coord(ys + int'($urandom_range(8)) - 4);
    end else begin
      d = int'($urandom_range(126)) - 63;
      case ($urandom_range(2))
        0: begin
          xe = clamp_coord(xs + d);
          ye = ys;
        end
        1: begin
          xe = xs;
          ye = clamp_coord(ys + d);
        end
        default: begin
          xe = clamp_coord(xs + d);
          ye = clamp_coord(ys - d);
        end
      endcase
    end
    send_segment(xs, ys, xe, ye);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero-length segments at two corners, the centre and one inner point.
    send_segment(-32, -32, -32, -32);
    send_segment(31, 31, 31, 31);
    send_segment(0, 0, 0, 0);
    send_segment(-1, 5, -1, 5);
    // Full-length diagonals in both directions, one horizontal and one vertical.
    send_segment(-32, -32, 31, 31);
    send_segment(31, 31, -32, -32);
    send_segment(31, -32, -32, 31);
    send_segment(-32, 31, 31, -32);
    send_segment(-32, 0, 31, 0);
    send_segment(5, 31, 5, -32);
    // Exact halves: round away from zero on both sides of the axis.
    send_segment(0, 0, 4, 1);
    send_segment(0, 0, 4, -1);
    send_segment(0, 0, -4, -1);
    send_segment(0, 0, 1, 4);
    send_segment(3, -2, -3, 1);
    // Single steps and long shallow and steep runs.
    send_segment(0, 0, 1, 1);
    send_segment(-1, -1, 0, 0);
    send_segment(-32, -32, -31, 31);
    send_segment(-32, 31, 31, 30);
    send_segment(10, -7, -7, 10);

    // Random: sender light and receiver heavy, then swapped, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          take_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          take_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RandomItems / 3 + (phase == 0 ? RandomItems % 3 : 0); n++)
        send_random_segment();
    end
    in_valid <= 1'b0;

    // Drain every predicted point, then watch a little longer for strays.
    while (point_board.pending_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d segments (longest %0d steps), %0d points checked, %0d mismatches.",
             point_board.segments_seen, point_board.longest_segment,
             point_board.points_checked, point_board.mismatch_count);
    if (point_board.mismatch_count == 0 && point_board.pending_count() == 0) begin
      $display("dda_line_rasterizer_unit regression: pass");
    end else begin
      $display("dda_line_rasterizer_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dlr_pkg.sv
src/dlr_axis.sv
src/dlr_datapath.sv
src/dlr_ctrl.sv
src/dda_line_rasterizer_unit.sv
tb/sv/dda_line_rasterizer_unit_tb.sv
